// ===== hdl/tlnvf_pkg.sv =====
`default_nettype none
package tlnvf_pkg;

  // byte slots for one rendered text byte (M- ^ X is the longest form)
  localparam int unsigned CharSlots  = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_NONPRINTING = 3'd3,
    REG_SHOW_ENDS        = 3'd4,
    REG_SHOW_TABS        = 3'd5
  } reg_idx_e;

  localparam logic [7:0] ChTab      = 8'd9;
  localparam logic [7:0] ChNewline  = 8'd10;
  localparam logic [7:0] ChSpace    = 8'd32;
  localparam logic [7:0] ChDollar   = 8'd36;
  localparam logic [7:0] ChDash     = 8'd45;
  localparam logic [7:0] ChZero     = 8'd48;
  localparam logic [7:0] ChQuestion = 8'd63;
  localparam logic [7:0] ChCtlShift = 8'd64;
  localparam logic [7:0] ChUpperI   = 8'd73;
  localparam logic [7:0] ChUpperM   = 8'd77;
  localparam logic [7:0] ChCaret    = 8'd94;
  localparam logic [6:0] ChDelete7  = 7'd127;

  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_nonprinting;
    logic show_ends;
    logic show_tabs;
  } cfg_t;

  // one queued work item: optional line number plus 1..4 rendered bytes
  typedef struct packed {
    logic                           number;
    logic [CharSlots-1:0][7:0]      chars;
    logic [$clog2(CharSlots)-1:0]   char_last;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/tlnvf_front.sv =====
`default_nettype none
module tlnvf_front #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  tlnvf_pkg::cfg_t              cfg_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [7:0]                   data_byte_i,
  input  wire                          file_start_i,
  input  wire                          full_i,
  output logic                         push_o,
  output tlnvf_pkg::job_t              push_job_o,
  output logic [4*NUMBER_DIGITS-1:0]   push_bcd_o
);

  localparam int unsigned BcdW = 4 * NUMBER_DIGITS;

  logic            at_line_start_q, at_line_start_d;
  logic [1:0]      blank_run_q, blank_run_d;
  logic [BcdW-1:0] bcd_q, bcd_d, bcd_inc;
  logic            accept;
  logic            line_start, blank, squeezed, advance;
  logic [1:0]      run_eff, run_new;
  logic [NUMBER_DIGITS:0] carry;
  logic            all_nine;
  tlnvf_pkg::job_t rend;

  function automatic tlnvf_pkg::job_t render_char(input logic [7:0] c,
                                                   input tlnvf_pkg::cfg_t cfg);
    tlnvf_pkg::job_t j;
    logic [6:0]      low;
    j   = '0;
    low = c[6:0];
    if (c == tlnvf_pkg::ChNewline) begin
      if (cfg.show_ends) begin
        j.chars[0]  = tlnvf_pkg::ChDollar;
        j.chars[1]  = tlnvf_pkg::ChNewline;
        j.char_last = 2'd1;
      end else begin
        j.chars[0]  = tlnvf_pkg::ChNewline;
        j.char_last = 2'd0;
      end
    end else if (c == tlnvf_pkg::ChTab && cfg.show_tabs) begin
      j.chars[0]  = tlnvf_pkg::ChCaret;
      j.chars[1]  = tlnvf_pkg::ChUpperI;
      j.char_last = 2'd1;
    end else if (!cfg.show_nonprinting) begin
      j.chars[0]  = c;
      j.char_last = 2'd0;
    end else if (c[7]) begin
      // meta prefix, then the low seven bits in caret form where needed
      j.chars[0] = tlnvf_pkg::ChUpperM;
      j.chars[1] = tlnvf_pkg::ChDash;
      if (low[6:5] == 2'b00) begin
        j.chars[2]  = tlnvf_pkg::ChCaret;
        j.chars[3]  = {1'b0, low} + tlnvf_pkg::ChCtlShift;
        j.char_last = 2'd3;
      end else if (low == tlnvf_pkg::ChDelete7) begin
        j.chars[2]  = tlnvf_pkg::ChCaret;
        j.chars[3]  = tlnvf_pkg::ChQuestion;
        j.char_last = 2'd3;
      end else begin
        j.chars[2]  = c & 8'h7f;
        j.char_last = 2'd2;
      end
    end else if (c[6:5] == 2'b00 && c != tlnvf_pkg::ChTab) begin
      j.chars[0]  = tlnvf_pkg::ChCaret;
      j.chars[1]  = c + tlnvf_pkg::ChCtlShift;
      j.char_last = 2'd1;
    end else if (low == tlnvf_pkg::ChDelete7) begin
      j.chars[0]  = tlnvf_pkg::ChCaret;
      j.chars[1]  = tlnvf_pkg::ChQuestion;
      j.char_last = 2'd1;
    end else begin
      j.chars[0]  = c;
      j.char_last = 2'd0;
    end
    return j;
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // bcd increment, carry ripples through trailing nines; all_nine marks the value at which the count saturates
  always_comb begin
    carry[0] = 1'b1;
    all_nine = 1'b1;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      carry[d+1] = carry[d] && (bcd_q[4*d +: 4] >= 4'd9);
      if (bcd_q[4*d +: 4] != 4'd9) all_nine = 1'b0;
      if (!carry[d]) begin
        bcd_inc[4*d +: 4] = bcd_q[4*d +: 4];
      end else if (bcd_q[4*d +: 4] >= 4'd9) begin
        bcd_inc[4*d +: 4] = 4'd0;
      end else begin
        bcd_inc[4*d +: 4] = bcd_q[4*d +: 4] + 4'd1;
      end
    end
  end

  always_comb begin
    line_start = file_start_i || at_line_start_q;
    run_eff    = file_start_i ? 2'd0 : blank_run_q;
    blank      = (data_byte_i == tlnvf_pkg::ChNewline);
    if (blank) begin
      run_new = (run_eff == 2'd2) ? 2'd2 : run_eff + 2'd1;
    end else begin
      run_new = 2'd0;
    end
    squeezed = line_start && cfg_i.squeeze_blank && (run_new == 2'd2);
    advance  = line_start && !squeezed && !(cfg_i.number_nonblank && blank) && !all_nine;

    rend = render_char(data_byte_i, cfg_i);
    if (cfg_i.number_nonblank) begin
      rend.number = line_start && !blank;
    end else begin
      rend.number = line_start && cfg_i.number_all;
    end

    at_line_start_d = at_line_start_q;
    blank_run_d     = blank_run_q;
    bcd_d           = bcd_q;
    if (accept) begin
      blank_run_d     = line_start ? run_new : run_eff;
      at_line_start_d = squeezed ? 1'b1 : blank;
      if (advance) bcd_d = bcd_inc;
    end
  end

  assign push_o     = accept && !squeezed;
  assign push_job_o = rend;
  assign push_bcd_o = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      blank_run_q     <= 2'd0;
      bcd_q           <= BcdW'(1);
    end else begin
      at_line_start_q <= at_line_start_d;
      blank_run_q     <= blank_run_d;
      bcd_q           <= bcd_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tlnvf_queue.sv =====
`default_nettype none
module tlnvf_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  wire  [DATA_W-1:0] push_data_i,
  input  wire               pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output logic [DATA_W-1:0] head_data_o
);

  localparam int unsigned PtrW = tlnvf_pkg::QueuePtrW;
  localparam int unsigned CntW = PtrW + 1;

  logic [DATA_W-1:0] mem_q [tlnvf_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o       = (count_q == CntW'(tlnvf_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tlnvf_back.sv =====
`default_nettype none
module tlnvf_back #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        head_valid_i,
  input  tlnvf_pkg::job_t            head_job_i,
  input  wire  [4*NUMBER_DIGITS-1:0] head_bcd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o
);

  localparam int unsigned PosW = $clog2(NUMBER_DIGITS + 5);

  logic [PosW-1:0] pos_q, num_len, end_pos, char_pos;
  logic            lead_q;
  logic            out_valid_q, out_last_q;
  logic [7:0]      out_byte_q;
  logic            step, last;
  logic [7:0]      cur_byte;
  logic [3:0]      dig;
  logic            in_digits, low_digit;

  assign num_len  = head_job_i.number ? PosW'(NUMBER_DIGITS + 1) : '0;
  assign end_pos  = num_len + PosW'(head_job_i.char_last);
  assign char_pos = pos_q - num_len;
  assign last     = (pos_q == end_pos);
  assign step     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = step && last;

  always_comb begin
    dig = 4'd0;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (pos_q == PosW'(NUMBER_DIGITS - 1 - d)) dig = head_bcd_i[4*d +: 4];
    end
    if (dig > 4'd9) dig = 4'd9;
    in_digits = head_job_i.number && (pos_q < PosW'(NUMBER_DIGITS));
    low_digit = (pos_q == PosW'(NUMBER_DIGITS - 1));

    if (in_digits) begin
      // leading zeros print as spaces, the units digit always prints
      if (lead_q && dig == 4'd0 && !low_digit) begin
        cur_byte = tlnvf_pkg::ChSpace;
      end else begin
        cur_byte = tlnvf_pkg::ChZero + {4'd0, dig};
      end
    end else if (head_job_i.number && pos_q == PosW'(NUMBER_DIGITS)) begin
      cur_byte = tlnvf_pkg::ChTab;
    end else begin
      cur_byte = head_job_i.chars[char_pos[1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= cur_byte;
      out_last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      lead_q      <= 1'b1;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        if (last) begin
          pos_q  <= '0;
          lead_q <= 1'b1;
        end else begin
          pos_q <= pos_q + PosW'(1);
          if (in_digits && dig != 4'd0) lead_q <= 1'b0;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule
`default_nettype wire

// ===== hdl/text_line_number_visible_filter.sv =====
// with the job queue empty, an item transferred in is written to the queue, reaches its head, and its
// first output byte is then registered in the back before it is presented and can transfer out
// throughput: one output byte per cycle while out_stall_i is low; items are 1 to NUMBER_DIGITS+5 bytes
// input takes one item per cycle until the four-entry job queue fills
// a squeezed blank line takes its input transfer and makes no output
// reset (async, active low): config clears, count is 1, line start set, queue empty
`default_nettype none
module text_line_number_visible_filter #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration write port
  input  wire                               cfg_we_i,
  input  wire  [tlnvf_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire                               cfg_wdata_i,
  // input text bytes
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [7:0]                        data_byte_i,
  input  wire                               file_start_i,
  // output text bytes
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic                              last_of_run_o
);

  localparam int unsigned BcdW   = 4 * NUMBER_DIGITS;
  localparam int unsigned JobW   = $bits(tlnvf_pkg::job_t);
  localparam int unsigned EntryW = JobW + BcdW;

  tlnvf_pkg::cfg_t cfg_q;

  // front to queue
  logic              push;
  tlnvf_pkg::job_t   push_job;
  logic [BcdW-1:0]   push_bcd;
  logic              full;

  // queue to back
  logic              head_valid, pop;
  logic [EntryW-1:0] head_entry;
  tlnvf_pkg::job_t   head_job;
  logic [BcdW-1:0]   head_bcd;

  // option registers, to be written only while the block is idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (tlnvf_pkg::reg_idx_e'(cfg_idx_i))
        tlnvf_pkg::REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_wdata_i;
        tlnvf_pkg::REG_NUMBER_ALL:       cfg_q.number_all       <= cfg_wdata_i;
        tlnvf_pkg::REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_wdata_i;
        tlnvf_pkg::REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_wdata_i;
        tlnvf_pkg::REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_wdata_i;
        tlnvf_pkg::REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: line tracking, squeeze, line count and byte rendering
  tlnvf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .file_start_i(file_start_i),
    .full_i      (full),
    .push_o      (push),
    .push_job_o  (push_job),
    .push_bcd_o  (push_bcd)
  );

  // job queue decouples classification from byte output
  tlnvf_queue #(
    .DATA_W(EntryW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_bcd, push_job}),
    .pop_i       (pop),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_data_o (head_entry)
  );

  assign head_job = tlnvf_pkg::job_t'(head_entry[JobW-1:0]);
  assign head_bcd = head_entry[EntryW-1:JobW];

  // back: serializes line number digits, tab and rendered bytes
  tlnvf_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .head_bcd_i   (head_bcd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
`default_nettype wire
